// ----- rtl/core/telemetry_frame_deframer_macros.svh -----
// Assertion macros for the telemetry deframer port checker
`ifndef TELEMETRY_FRAME_DEFRAMER_MACROS_SVH
`define TELEMETRY_FRAME_DEFRAMER_MACROS_SVH

// same-cycle implication, off while reset is high
`define TFD_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tfd check failed");

// next-cycle implication, off while reset is high
`define TFD_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tfd check failed");

// next-cycle implication, live through reset
`define TFD_ASSERT_ALWAYS(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("tfd check failed");

`endif

// ----- rtl/core/tfd_pkg.sv -----
// Shared types and constants of the telemetry frame deframer
package tfd_pkg;

   localparam logic [7:0] FlagByte      = 8'h7e;
   localparam logic [7:0] TypeStd       = 8'hfe;
   localparam int         StoreDepth    = 5;
   localparam int         CountWidth    = 4;
   localparam int         IndexWidth    = $clog2(StoreDepth);
   localparam logic [CountWidth-1:0] MaxFrameBytes = CountWidth'(11);

   typedef enum logic [2:0] {
      PH_IDLE = 3'b001,
      PH_OPEN = 3'b010,
      PH_DATA = 3'b100
   } phase_type;

   typedef struct packed {
      logic [7:0] volt_a1;
      logic [7:0] volt_a2;
      logic [7:0] rssi_rx;
      logic [6:0] rssi_tx;
   } rsp_type;

   typedef struct packed {
      logic       go;
      logic [7:0] rx_byte;
   } beat_type;

   typedef struct packed {
      logic    push;
      rsp_type data;
   } result_type;

endpackage

// ----- rtl/core/tfd_in_stage.sv -----
// Input register of the telemetry frame deframer
module tfd_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_rx_byte,
   input  logic              full,
   output tfd_pkg::beat_type beat
);
   import tfd_pkg::*;

   logic       in_valid_ff;
   logic       in_valid_in;
   logic [7:0] in_byte_ff;
   logic       go;
   logic       accept;

   assign go        = in_valid_ff && !full;
   assign req_stall = reset || (in_valid_ff && full);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (go) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   assign beat.go      = go;
   assign beat.rx_byte = in_byte_ff;

endmodule

// ----- rtl/core/tfd_parser.sv -----
// Frame state machine and byte store of the telemetry frame deframer
module tfd_parser (
   input  logic                clock,
   input  logic                reset,
   input  tfd_pkg::beat_type   beat,
   output tfd_pkg::result_type result
);
   import tfd_pkg::*;

   phase_type             phase_ff;
   phase_type             phase_in;
   logic [CountWidth-1:0] count_ff;
   logic [CountWidth-1:0] count_in;
   logic [7:0]            store_ff [StoreDepth];
   logic                  keep;
   logic                  emit;
   logic                  is_flag;

   assign is_flag = beat.rx_byte == FlagByte;

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      keep     = 1'b0;
      emit     = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            if (is_flag) begin
               phase_in = PH_OPEN;
               count_in = '0;
            end
         end
         PH_OPEN: begin
            if (!is_flag) begin
               keep     = 1'b1;
               phase_in = PH_DATA;
            end
         end
         PH_DATA: begin
            if (!is_flag) begin
               if (count_ff >= MaxFrameBytes) begin
                  phase_in = PH_IDLE;
               end else begin
                  keep = 1'b1;
               end
            end else begin
               phase_in = PH_IDLE;
               emit     = store_ff[0] == TypeStd;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
      if (keep) begin
         count_in = count_ff + CountWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         count_ff <= '0;
      end else if (beat.go) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < StoreDepth; i++) begin
            store_ff[i] <= '0;
         end
      end else if (beat.go && keep && count_ff < CountWidth'(StoreDepth)) begin
         store_ff[count_ff[IndexWidth-1:0]] <= beat.rx_byte;
      end
   end

   assign result.push         = beat.go && emit;
   assign result.data.volt_a1 = store_ff[1];
   assign result.data.volt_a2 = store_ff[2];
   assign result.data.rssi_rx = store_ff[3];
   assign result.data.rssi_tx = store_ff[4][7:1];

endmodule

// ----- rtl/core/tfd_rsp_fifo.sv -----
// Two-entry result buffer of the telemetry frame deframer
module tfd_rsp_fifo (
   input  logic                clock,
   input  logic                reset,
   input  tfd_pkg::result_type result,
   output logic                full,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output tfd_pkg::rsp_type    rsp_data
);
   import tfd_pkg::*;

   logic [1:0] count_ff;
   logic [1:0] count_in;
   rsp_type    head_ff;
   rsp_type    tail_ff;
   logic       pop;

   assign rsp_valid = !reset && count_ff != 2'd0;
   assign pop       = rsp_valid && !rsp_stall;
   assign full      = count_ff == 2'd2;
   assign rsp_data  = head_ff;

   always_comb begin
      count_in = count_ff;
      if (result.push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (!result.push && pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && count_ff == 2'd2) begin
         head_ff <= tail_ff;
      end else if (result.push && (count_ff == 2'd0 || (pop && count_ff == 2'd1))) begin
         head_ff <= result.data;
      end
      if (result.push && ((count_ff == 2'd1 && !pop) || (count_ff == 2'd2 && pop))) begin
         tail_ff <= result.data;
      end
   end

endmodule

// ----- rtl/core/telemetry_frame_deframer.sv -----
// Top level of the telemetry frame deframer
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_rx_byte
//   rsp      out        rsp_valid/rsp_stall  rsp_volt_a1, rsp_volt_a2, rsp_rssi_rx, rsp_rssi_tx
//
// One byte per cycle unless req_stall; results pass the input register and result buffer.
// The input register and the frame state step once per cycle, and hold while the result buffer is full.
// Reset clears the frame state, the byte store and both buffers.
// rsp_stall fills the two-entry result buffer, then req_stall rises.
module telemetry_frame_deframer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_volt_a1,
   output logic [7:0] rsp_volt_a2,
   output logic [7:0] rsp_rssi_rx,
   output logic [6:0] rsp_rssi_tx
);
   import tfd_pkg::*;

   beat_type   beat;
   result_type result;
   rsp_type    rsp_data;
   logic       full;

   tfd_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .full        (full),
      .beat        (beat)
   );

   tfd_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .beat   (beat),
      .result (result)
   );

   tfd_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .result    (result),
      .full      (full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_volt_a1 = rsp_data.volt_a1;
   assign rsp_volt_a2 = rsp_data.volt_a2;
   assign rsp_rssi_rx = rsp_data.rssi_rx;
   assign rsp_rssi_tx = rsp_data.rssi_tx;

endmodule

// ----- rtl/core/tfd_checker.sv -----
// Port checker of the telemetry frame deframer and its bind
`include "telemetry_frame_deframer_macros.svh"

module tfd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [7:0] req_rx_byte,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_volt_a1,
   input logic [7:0] rsp_volt_a2,
   input logic [7:0] rsp_rssi_rx,
   input logic [6:0] rsp_rssi_tx
);
   import tfd_pkg::*;

   logic rsp_hold;
   logic flag_accept;

   assign rsp_hold    = rsp_valid && rsp_stall;
   assign flag_accept = req_valid && !req_stall && req_rx_byte == FlagByte;

   `TFD_ASSERT_NEXT(a_rsp_hold, rsp_hold, rsp_valid)
   `TFD_ASSERT_NEXT(a_volt_stable, rsp_hold, $stable(rsp_volt_a1) && $stable(rsp_volt_a2))
   `TFD_ASSERT_NEXT(a_rssi_stable, rsp_hold, $stable(rsp_rssi_rx) && $stable(rsp_rssi_tx))
   `TFD_ASSERT_ALWAYS(a_reset_empty, reset, !rsp_valid)
   `TFD_ASSERT_NOW(a_rsp_after_flag, $rose(rsp_valid), $past(flag_accept, 2))

endmodule

bind telemetry_frame_deframer tfd_checker u_tfd_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_rx_byte (req_rx_byte),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_volt_a1 (rsp_volt_a1),
   .rsp_volt_a2 (rsp_volt_a2),
   .rsp_rssi_rx (rsp_rssi_rx),
   .rsp_rssi_tx (rsp_rssi_tx)
);

// ----- dv/telemetry_frame_deframer_checker.sv -----
// Checker for the telemetry frame deframer: watches both channels, predicts and compares results
module telemetry_frame_deframer_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_rx_byte,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_volt_a1,
   input  logic [7:0] rsp_volt_a2,
   input  logic [7:0] rsp_rssi_rx,
   input  logic [6:0] rsp_rssi_tx,
   output int         mismatches,
   output int         pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import tfd_pkg::*;

   phase_type             fr_phase;
   logic [CountWidth-1:0] fr_count;
   logic [7:0]            fr_store [StoreDepth];
   rsp_type               telemetry_q [$];
   int                    fail_count;

   task automatic store_byte(input logic [7:0] b);
      if (fr_count < StoreDepth) begin
         fr_store[fr_count[IndexWidth-1:0]] = b;
      end
      fr_count = fr_count + 1'b1;
   endtask

   task automatic deframe_byte(input logic [7:0] b);
      rsp_type telemetry;
      case (fr_phase)
         PH_IDLE: begin
            if (b == FlagByte) begin
               fr_phase = PH_OPEN;
               fr_count = '0;
            end
         end
         PH_OPEN: begin
            if (b != FlagByte) begin
               store_byte(b);
               fr_phase = PH_DATA;
            end
         end
         PH_DATA: begin
            if (b != FlagByte) begin
               if (fr_count >= MaxFrameBytes) begin
                  fr_phase = PH_IDLE;
               end else begin
                  store_byte(b);
               end
            end else begin
               fr_phase = PH_IDLE;
               if (fr_store[0] == TypeStd) begin
                  telemetry.volt_a1 = fr_store[1];
                  telemetry.volt_a2 = fr_store[2];
                  telemetry.rssi_rx = fr_store[3];
                  telemetry.rssi_tx = fr_store[4][7:1];
                  telemetry_q.push_back(telemetry);
               end
            end
         end
         default: begin
            fr_phase = PH_IDLE;
         end
      endcase
   endtask

   task automatic check_telemetry();
      rsp_type want;
      bit      bad;
      if (telemetry_q.size() == 0) begin
         fail_count++;
         if (fail_count <= 10) begin
            $display("%0t: unexpected rsp beat a1=%h a2=%h rx=%h tx=%h", $realtime,
                     rsp_volt_a1, rsp_volt_a2, rsp_rssi_rx, rsp_rssi_tx);
         end
      end else begin
         want = telemetry_q.pop_front();
         bad  = (rsp_volt_a1 !== want.volt_a1) || (rsp_volt_a2 !== want.volt_a2) ||
                (rsp_rssi_rx !== want.rssi_rx) || (rsp_rssi_tx !== want.rssi_tx);
         if (bad) begin
            fail_count++;
            if (fail_count <= 10) begin
               $display("%0t: rsp mismatch exp %h %h %h %h got %h %h %h %h",
                        $realtime, want.volt_a1, want.volt_a2, want.rssi_rx, want.rssi_tx,
                        rsp_volt_a1, rsp_volt_a2, rsp_rssi_rx, rsp_rssi_tx);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         fr_phase = PH_IDLE;
         fr_count = '0;
         foreach (fr_store[i]) begin
            fr_store[i] = 8'h00;
         end
         telemetry_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            check_telemetry();
         end
         if (req_valid && !req_stall) begin
            deframe_byte(req_rx_byte);
         end
      end
      mismatches <= fail_count;
      pending    <= telemetry_q.size();
   end

endmodule

// ----- dv/telemetry_frame_deframer_tb.sv -----
// Testbench top for the telemetry frame deframer: clock, reset, stimulus and verdict
module telemetry_frame_deframer_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tfd_pkg::*;

   localparam int ItemTarget = 1550;
   localparam int CycleLimit = 200000;
   localparam int LongHold   = 400;
   localparam int TailCycles = 20;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_stall;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall   = 1'b0;
   logic [7:0] rsp_volt_a1;
   logic [7:0] rsp_volt_a2;
   logic [7:0] rsp_rssi_rx;
   logic [6:0] rsp_rssi_tx;
   int         mismatches;
   int         pending;

   int cycle_count    = 0;
   int beats_sent     = 0;
   int beats_in_burst = 1;
   int hold_asks      = 0;
   int holds_done     = 0;

   logic [7:0] directed_beats [27] = '{
      FlagByte, TypeStd, FlagByte,
      FlagByte, FlagByte, TypeStd, 8'h00, 8'hff, 8'h80, 8'hff, FlagByte,
      FlagByte, TypeStd, 8'h12, 8'h34, 8'h56, 8'h79, 8'h9a, 8'hbc, 8'hde, 8'hf0, 8'h0f,
      8'h01, 8'h55,
      FlagByte, TypeStd, FlagByte
   };

   telemetry_frame_deframer u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_volt_a1 (rsp_volt_a1),
      .rsp_volt_a2 (rsp_volt_a2),
      .rsp_rssi_rx (rsp_rssi_rx),
      .rsp_rssi_tx (rsp_rssi_tx)
   );

   telemetry_frame_deframer_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_volt_a1 (rsp_volt_a1),
      .rsp_volt_a2 (rsp_volt_a2),
      .rsp_rssi_rx (rsp_rssi_rx),
      .rsp_rssi_tx (rsp_rssi_tx),
      .mismatches  (mismatches),
      .pending     (pending)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CycleLimit) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // receiver: own stall pattern, plus a long hold-off on request
   initial begin
      int run;
      forever begin
         if (hold_asks != holds_done) begin
            rsp_stall <= 1'b1;
            repeat (LongHold) @(negedge clock);
            holds_done++;
         end
         if ($urandom_range(0, 7) == 0) begin
            run = $urandom_range(10, 40);
            rsp_stall <= 1'b0;
         end else begin
            run = $urandom_range(1, 6);
            rsp_stall <= ($urandom_range(0, 2) == 0);
         end
         repeat (run) @(negedge clock);
      end
   end

   task automatic offer(input logic [7:0] b, input bit counted);
      int gap;
      @(negedge clock);
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      if (counted) begin
         beats_sent++;
      end
      beats_in_burst--;
      if (beats_in_burst <= 0) begin
         beats_in_burst = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic send_frame();
      int         len;
      logic [7:0] b;
      if ($urandom_range(0, 7) == 0) begin
         repeat ($urandom_range(1, 4)) offer(8'($urandom_range(0, 255)), 1'b0);
      end
      offer(FlagByte, 1'b1);
      if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 3)) offer(FlagByte, 1'b1);
      end
      b = ($urandom_range(0, 3) != 0) ? TypeStd : 8'($urandom_range(0, 255));
      offer(b, 1'b1);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 14) : $urandom_range(0, 10);
      repeat (len) offer(8'($urandom_range(0, 255)), 1'b1);
      if ($urandom_range(0, 9) != 0) begin
         offer(FlagByte, 1'b1);
      end
   endtask

   initial begin
      int frame_no;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_beats[i]) begin
         offer(directed_beats[i], 1'b1);
      end
      drain_results();

      frame_no = 0;
      while (beats_sent < ItemTarget) begin
         if (frame_no == 40 || frame_no == 160) begin
            hold_asks++;
         end
         if (frame_no == 100) begin
            drain_results();
         end
         send_frame();
         frame_no++;
      end

      drain_results();
      repeat (TailCycles) @(negedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
